### hw/rtl/dlr_pkg.sv
package dlr_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int COLOR_BITS     = 24;
   localparam int QUEUE_DEPTH    = 2;

   typedef enum logic {
      ACT_START = 1'b0,
      ACT_STEP  = 1'b1
   } action_type;

   localparam logic STAT_PIXEL     = 1'b0;
   localparam logic STAT_IDLE_STEP = 1'b1;

endpackage

### hw/rtl/dda_line_rasterizer_unit.sv
// channel | dir | ports                    | word
// req     | in  | req_tvalid/tready/tdata  | tuser action, tdata endpoints and color
// rsp     | out | rsp_tvalid/tready/tdata  | tdata pixel, tlast final pixel, tuser status
//
// in the back end, step words stream at one pixel per cycle while the output is free
// a start word goes through load, FRAC_BITS + 1 divider iterations
//   (one quotient bit per cycle) and the first pixel
// synchronous reset empties the two-word queue, drops the active line and the output word
// rsp_tready low holds the output register; the queue keeps taking words until full
module dda_line_rasterizer_unit #(
   parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // start_x, start_y, end_x, end_y, line_color, zero fill
   input  logic [((4 * COORD_BITS + dlr_pkg::COLOR_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // action
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // pixel_x, pixel_y, pixel_color, zero fill
   output logic [((2 * COORD_BITS + dlr_pkg::COLOR_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // last_pixel
   output logic rsp_tlast,
   // status
   output logic rsp_tuser
);

   localparam int REQ_DW  = ((4 * COORD_BITS + dlr_pkg::COLOR_BITS + 7) / 8) * 8;
   localparam int RSP_DW  = ((2 * COORD_BITS + dlr_pkg::COLOR_BITS + 7) / 8) * 8;
   localparam int ENTRY_W = 3 + 4 * COORD_BITS + dlr_pkg::COLOR_BITS;

   logic               q_push, q_wready, q_valid, q_pop;
   logic [ENTRY_W-1:0] q_wdata, q_rdata;

   dlr_front #(
      .COORD_BITS(COORD_BITS),
      .REQ_DW    (REQ_DW),
      .ENTRY_W   (ENTRY_W)
   ) u_front (
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .q_push    (q_push),
      .q_wready  (q_wready),
      .q_wdata   (q_wdata)
   );

   dlr_queue #(
      .WIDTH(ENTRY_W),
      .DEPTH(dlr_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_ready(q_wready),
      .wdata     (q_wdata),
      .pop_valid (q_valid),
      .pop       (q_pop),
      .rdata     (q_rdata)
   );

   dlr_back #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS),
      .RSP_DW    (RSP_DW),
      .ENTRY_W   (ENTRY_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_rdata   (q_rdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

endmodule

### hw/rtl/dlr_front.sv
module dlr_front #(
   parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
   parameter int REQ_DW     = 72,
   parameter int ENTRY_W    = 3 + 4 * COORD_BITS + dlr_pkg::COLOR_BITS
) (
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [REQ_DW-1:0]  req_tdata,
   input  logic               req_tuser,
   output logic               q_push,
   input  logic               q_wready,
   output logic [ENTRY_W-1:0] q_wdata
);

   localparam int C = COORD_BITS;

   logic [C-1:0] x1, y1, x2, y2;
   logic [C-1:0] adx, ady;
   logic [C-1:0] p1, q1, p2, q2;
   logic [C-1:0] a1, b1, a2, b2;
   logic [C-1:0] dmin;
   logic         steep, neg;
   logic [dlr_pkg::COLOR_BITS-1:0] color;

   always_comb begin
      x1    = req_tdata[C-1:0];
      y1    = req_tdata[2*C-1:C];
      x2    = req_tdata[3*C-1:2*C];
      y2    = req_tdata[4*C-1:3*C];
      color = req_tdata[4*C+dlr_pkg::COLOR_BITS-1:4*C];

      adx   = (x2 >= x1) ? x2 - x1 : x1 - x2;
      ady   = (y2 >= y1) ? y2 - y1 : y1 - y2;
      steep = ady > adx;

      // major axis first, minor second
      p1 = steep ? y1 : x1;
      q1 = steep ? x1 : y1;
      p2 = steep ? y2 : x2;
      q2 = steep ? x2 : y2;

      // order so the major coordinate ascends
      if (p1 > p2) begin
         a1 = p2; b1 = q2; a2 = p1; b2 = q1;
      end else begin
         a1 = p1; b1 = q1; a2 = p2; b2 = q2;
      end

      neg  = b2 < b1;
      dmin = neg ? b1 - b2 : b2 - b1;
   end

   assign req_tready = q_wready;
   assign q_push     = req_tvalid;
   // entry from lsb: kind, steep, neg, a1, a2, b1, dmin, color
   assign q_wdata    = {color, dmin, b1, a2, a1, neg, steep, req_tuser};

endmodule

### hw/rtl/dlr_queue.sv
module dlr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = dlr_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             push_ready,
   input  logic [WIDTH-1:0] wdata,
   output logic             pop_valid,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign push_ready = cnt_ff != NW'(DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;
   assign rdata      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= NW'(DEPTH))
      else $error("queue count above depth");

endmodule

### hw/rtl/dlr_back.sv
module dlr_back #(
   parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF,
   parameter int RSP_DW     = 48,
   parameter int ENTRY_W    = 3 + 4 * COORD_BITS + dlr_pkg::COLOR_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_pop,
   input  logic [ENTRY_W-1:0] q_rdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_DW-1:0]  rsp_tdata,
   output logic               rsp_tlast,
   output logic               rsp_tuser
);

   localparam int C   = COORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int CB  = dlr_pkg::COLOR_BITS;
   localparam int CW  = $clog2(F + 1);
   localparam int PAD = RSP_DW - 2 * C - CB;

   typedef enum logic [1:0] {
      S_READY,
      S_DIV,
      S_EMIT
   } state_type;

   state_type       state_ff;
   logic [C-1:0]    pos_ff, end_ff, divisor_ff;
   logic [C+F-1:0]  acc_ff;
   logic [F+1:0]    slope_ff;
   logic            steep_ff, neg_ff, active_ff;
   logic [CB-1:0]   color_ff;
   logic [C:0]      rem_ff;
   logic [F:0]      quot_ff;
   logic [CW-1:0]   cnt_ff;
   logic            rsp_valid_ff, rsp_last_ff, rsp_status_ff;
   logic [RSP_DW-1:0] rsp_data_ff;

   // unpacked queue entry
   logic            e_kind, e_steep, e_neg;
   logic [C-1:0]    e_a1, e_a2, e_b1, e_dmin;
   logic [CB-1:0]   e_color;

   logic            out_free;
   logic            rsp_load;
   logic [C-1:0]    pos_in;
   logic [C+F-1:0]  acc_in;
   logic            div_ge;
   logic [C:0]      rem_diff, rem_keep, rem_in;
   logic [F:0]      mag;
   logic [F+1:0]    slope_in;

   function automatic logic [RSP_DW-1:0] pack_pixel(
      input logic [C-1:0]  minor,
      input logic [C-1:0]  major,
      input logic          steep,
      input logic [CB-1:0] color
   );
      logic [C-1:0] px, py;
      px = steep ? minor : major;
      py = steep ? major : minor;
      return {{PAD{1'b0}}, color, py, px};
   endfunction

   assign {e_color, e_dmin, e_b1, e_a2, e_a1, e_neg, e_steep, e_kind} = q_rdata;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign q_pop    = (state_ff == S_READY) && q_valid &&
                     (e_kind == dlr_pkg::ACT_START || out_free);
   // a new output word is loaded on a step pop or on the first pixel of a line
   assign rsp_load = (state_ff == S_READY && q_pop && e_kind == dlr_pkg::ACT_STEP) ||
                     (state_ff == S_EMIT && out_free);

   always_comb begin
      pos_in   = pos_ff + 1'b1;
      acc_in   = acc_ff + {{(C - 2){slope_ff[F+1]}}, slope_ff};
      // restoring divide, one quotient bit per cycle
      rem_diff = rem_ff - {1'b0, divisor_ff};
      div_ge   = rem_ff >= {1'b0, divisor_ff};
      rem_keep = div_ge ? rem_diff : rem_ff;
      rem_in   = {rem_keep[C-1:0], 1'b0};
      // zero-length line gets a zero slope
      mag      = (divisor_ff == '0) ? '0 : quot_ff;
      slope_in = neg_ff ? (F + 2)'(0) - {1'b0, mag} : {1'b0, mag};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_READY;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_tready);
         unique case (state_ff)
            S_READY: begin
               if (q_pop) begin
                  if (e_kind == dlr_pkg::ACT_START) begin
                     pos_ff     <= e_a1;
                     end_ff     <= e_a2;
                     acc_ff     <= {e_b1, {F{1'b0}}};
                     color_ff   <= e_color;
                     steep_ff   <= e_steep;
                     neg_ff     <= e_neg;
                     divisor_ff <= e_a2 - e_a1;
                     rem_ff     <= {1'b0, e_dmin};
                     quot_ff    <= '0;
                     cnt_ff     <= CW'(F);
                     state_ff   <= S_DIV;
                  end else if (active_ff) begin
                     pos_ff        <= pos_in;
                     acc_ff        <= acc_in;
                     active_ff     <= pos_in != end_ff;
                     rsp_data_ff   <= pack_pixel(acc_in[C+F-1:F], pos_in, steep_ff,
                                                 color_ff);
                     rsp_last_ff   <= pos_in == end_ff;
                     rsp_status_ff <= dlr_pkg::STAT_PIXEL;
                  end else begin
                     rsp_data_ff   <= '0;
                     rsp_last_ff   <= 1'b0;
                     rsp_status_ff <= dlr_pkg::STAT_IDLE_STEP;
                  end
               end
            end
            S_DIV: begin
               rem_ff  <= rem_in;
               quot_ff <= {quot_ff[F-1:0], div_ge};
               if (cnt_ff == '0) begin
                  state_ff <= S_EMIT;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  slope_ff      <= slope_in;
                  active_ff     <= pos_ff != end_ff;
                  rsp_data_ff   <= pack_pixel(acc_ff[C+F-1:F], pos_ff, steep_ff, color_ff);
                  rsp_last_ff   <= pos_ff == end_ff;
                  rsp_status_ff <= dlr_pkg::STAT_PIXEL;
                  state_ff      <= S_READY;
               end
            end
            default: state_ff <= S_READY;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_idle_step_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == dlr_pkg::STAT_IDLE_STEP
         |-> rsp_data_ff == '0 && !rsp_last_ff)
      else $error("idle step word carries pixel data");

   a_no_pop_in_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> !q_pop)
      else $error("queue popped during divide");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV && cnt_ff == '0 |=> state_ff == S_EMIT)
      else $error("divide did not finish on count");

   a_slope_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> divisor_ff == '0 || quot_ff <= {1'b1, {F{1'b0}}})
      else $error("slope magnitude above one");

endmodule

### bench/tb_dda_line_rasterizer_unit.sv
`timescale 1ns / 100ps

module tb_dda_line_rasterizer_unit;

   localparam int C = dlr_pkg::COORD_BITS_DEF;
   localparam int F = dlr_pkg::FRAC_BITS_DEF;
   localparam int CB = dlr_pkg::COLOR_BITS;
   localparam int CMAX = (1 << C) - 1;
   localparam int REQ_W = ((4 * C + CB + 7) / 8) * 8;
   localparam int RSP_W = ((2 * C + CB + 7) / 8) * 8;
   localparam int STALL_LIMIT = 3000;
   localparam int LONG_HOLD = 400;
   localparam int ITEM_TARGET = 1650;
   localparam int CALM_TAIL = 200;

   typedef struct {
      logic [C-1:0]  x;
      logic [C-1:0]  y;
      logic [CB-1:0] color;
      logic          last;
      logic          status;
   } pixel_word_type;

   // tracks the line being drawn and the pixels still owed by the block
   class pixel_scoreboard_type;
      logic [C-1:0]   major_pos;
      logic [C-1:0]   major_end;
      logic [C+F-1:0] minor_acc;
      logic [F+1:0]   slope;
      logic           steep;
      logic           active;
      logic [CB-1:0]  color;
      pixel_word_type owed_pixels[$];
      int errors, checked, starts, steps, idle_steps, last_pixels;

      function new();
         major_pos = '0;
         major_end = '0;
         minor_acc = '0;
         slope = '0;
         steep = 1'b0;
         active = 1'b0;
         color = '0;
      endfunction

      function void owe_pixel(logic last);
         pixel_word_type w;
         logic [C-1:0] minor;
         minor = minor_acc[C+F-1:F];
         w.x = steep ? minor : major_pos;
         w.y = steep ? major_pos : minor;
         w.color = color;
         w.last = last;
         w.status = dlr_pkg::STAT_PIXEL;
         owed_pixels.push_back(w);
      endfunction

      function void note_word(dlr_pkg::action_type act, logic [C-1:0] sx, logic [C-1:0] sy,
                              logic [C-1:0] ex, logic [C-1:0] ey,
                              logic [CB-1:0] col);
         logic [C-1:0] adx, ady, a1, b1, a2, b2, t, dmaj, dmin;
         logic [C+F-1:0] num, mag;
         logic neg;
         pixel_word_type w;
         if (act == dlr_pkg::ACT_START) begin
            starts++;
            adx = (ex >= sx) ? ex - sx : sx - ex;
            ady = (ey >= sy) ? ey - sy : sy - ey;
            steep = ady > adx;
            if (steep) begin
               a1 = sy; b1 = sx; a2 = ey; b2 = ex;
            end else begin
               a1 = sx; b1 = sy; a2 = ex; b2 = ey;
            end
            if (a1 > a2) begin
               t = a1; a1 = a2; a2 = t;
               t = b1; b1 = b2; b2 = t;
            end
            dmaj = a2 - a1;
            neg = b2 < b1;
            dmin = neg ? b1 - b2 : b2 - b1;
            num = {dmin, {F{1'b0}}};
            mag = (dmaj == 0) ? '0 : num / dmaj;
            slope = neg ? -mag[F+1:0] : mag[F+1:0];
            major_pos = a1;
            major_end = a2;
            minor_acc = {b1, {F{1'b0}}};
            color = col;
            active = a1 != a2;
            owe_pixel(!active);
         end else if (!active) begin
            idle_steps++;
            w.x = '0;
            w.y = '0;
            w.color = '0;
            w.last = 1'b0;
            w.status = dlr_pkg::STAT_IDLE_STEP;
            owed_pixels.push_back(w);
         end else begin
            steps++;
            major_pos = major_pos + 1'b1;
            minor_acc = minor_acc + {{(C+F-(F+2)){slope[F+1]}}, slope};
            active = major_pos != major_end;
            owe_pixel(!active);
         end
      endfunction

      function void check_word(logic [C-1:0] x, logic [C-1:0] y,
                               logic [CB-1:0] col, logic last, logic status);
         pixel_word_type w;
         if (owed_pixels.size() == 0) begin
            errors++;
            $display("%0t: unexpected pixel x=%h y=%h color=%h last=%b status=%b",
                     $time, x, y, col, last, status);
         end else begin
            w = owed_pixels.pop_front();
            checked++;
            if (w.last) last_pixels++;
            if (x !== w.x || y !== w.y || col !== w.color || last !== w.last ||
                status !== w.status) begin
               errors++;
               $display("%0t: pixel mismatch expected x=%h y=%h color=%h last=%b status=%b",
                        $time, w.x, w.y, w.color, w.last, w.status);
               $display("%0t:                  actual x=%h y=%h color=%h last=%b status=%b",
                        $time, x, y, col, last, status);
            end
         end
      endfunction

      function int pending();
         return owed_pixels.size();
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;
   logic             rsp_tuser;

   pixel_scoreboard_type sb;
   int  sent_count;
   int  stall_cycles;
   int  long_lines;
   bit  idle_on;
   bit  hold_rsp;

   dda_line_rasterizer_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // drop the request and keep it low for the given number of cycles
   task automatic hold_sender(input int cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_word(input dlr_pkg::action_type act, input logic [C-1:0] sx,
                            input logic [C-1:0] sy, input logic [C-1:0] ex,
                            input logic [C-1:0] ey, input logic [CB-1:0] col);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {col, ey, ex, sy, sx};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_word(act, sx, sy, ex, ey, col);
      sent_count++;
      idle_on = (sent_count < ITEM_TARGET - CALM_TAIL) && ((sent_count / 150) % 4 != 3);
      if (idle_on && $urandom_range(0, 5) == 0)
         hold_sender($urandom_range(1, 17));
   endtask

   // step words carry random endpoint bits, which the block ignores
   task automatic send_step();
      send_word(dlr_pkg::ACT_STEP, C'($urandom), C'($urandom), C'($urandom), C'($urandom),
                CB'($urandom));
   endtask

   task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
                            input logic [CB-1:0] col, input int nsteps);
      send_word(dlr_pkg::ACT_START, C'(sx), C'(sy), C'(ex), C'(ey), col);
      repeat (nsteps) send_step();
   endtask

   task automatic random_line();
      int kind, span, sx, sy, ex, ey, dx, dy, dmaj, nsteps, pick;
      kind = $urandom_range(0, 99);
      sx = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? CMAX : 0)
                                       : $urandom_range(0, CMAX);
      sy = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? CMAX : 0)
                                       : $urandom_range(0, CMAX);
      if (kind < 6) begin
         ex = $urandom_range(0, CMAX);
         ey = $urandom_range(0, CMAX);
      end else begin
         span = ($urandom_range(0, 3) == 0) ? 60 : 12;
         dx = $urandom_range(0, span);
         dy = $urandom_range(0, span);
         if ($urandom_range(0, 1)) dx = -dx;
         if ($urandom_range(0, 1)) dy = -dy;
         ex = (sx + dx < 0 || sx + dx > CMAX) ? sx - dx : sx + dx;
         ey = (sy + dy < 0 || sy + dy > CMAX) ? sy - dy : sy + dy;
      end
      dx = (ex >= sx) ? ex - sx : sx - ex;
      dy = (ey >= sy) ? ey - sy : sy - ey;
      dmaj = (dy > dx) ? dy : dx;
      pick = $urandom_range(0, 9);
      if (kind < 6) begin
         long_lines++;
         nsteps = $urandom_range(0, 30);
         if (nsteps > dmaj) nsteps = dmaj;
      end else if (pick == 0) begin
         nsteps = $urandom_range(0, dmaj);
      end else if (pick == 1) begin
         nsteps = dmaj + $urandom_range(1, 2);
      end else begin
         nsteps = dmaj;
      end
      draw_line(sx, sy, ex, ey, CB'($urandom), nsteps);
   endtask

   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         sb.check_word(rsp_tdata[C-1:0], rsp_tdata[2*C-1:C],
                       rsp_tdata[2*C+CB-1:2*C], rsp_tlast, rsp_tuser);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d pixels outstanding",
                  $time, stall_cycles, sb.pending());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      bit pressure_done, drain_done;
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      sent_count = 0;
      stall_cycles = 0;
      long_lines = 0;
      idle_on = 1'b1;
      hold_rsp = 1'b0;
      pressure_done = 1'b0;
      drain_done = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // step with no line, then zero-length lines at both corners
      send_step();
      draw_line(0, 0, 0, 0, 24'h000000, 1);
      draw_line(CMAX, CMAX, CMAX, CMAX, 24'hFFFFFF, 0);
      // shallow line run past its end
      draw_line(0, 0, 3, 2, 24'h123456, 4);
      // steep line with descending minor axis
      draw_line(10, 3, 7, 7, 24'hA5A5A5, 4);
      // equal deltas stay x-major; endpoints swapped
      draw_line(6, 2, 2, 6, 24'h5A5A5A, 4);
      // full-span lines, each abandoned by the next start
      draw_line(0, CMAX, CMAX, 0, 24'hFFFFFF, 2);
      draw_line(CMAX, 0, 0, CMAX, 24'h000000, 2);
      draw_line(100, 0, 100, CMAX, 24'hC0FFEE, 2);
      draw_line(0, 200, CMAX, 200, 24'h0F0F0F, 2);

      while (sent_count < ITEM_TARGET) begin
         if (!pressure_done && sent_count >= 700) begin
            // receiver goes quiet while a long line keeps streaming
            pressure_done = 1'b1;
            hold_rsp = 1'b1;
            draw_line(0, 5, 40, 30, CB'($urandom), 40);
         end else if (!drain_done && sent_count >= 1100) begin
            drain_done = 1'b1;
            hold_sender(1);
            while (sb.pending() != 0) @(negedge clock);
         end else if ($urandom_range(0, 11) == 0) begin
            send_step();
         end else begin
            random_line();
         end
      end

      hold_sender(1);
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.errors++;
         $display("%0t: %0d pixels never arrived", $time, sb.pending());
      end
      $display("covered %0d words: %0d line starts (%0d long), %0d pixel steps, %0d idle steps",
               sent_count, sb.starts, long_lines, sb.steps, sb.idle_steps);
      $display("checked %0d pixels, %0d of them final, with one long output stall and one drain",
               sb.checked, sb.last_pixels);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
